### rtl/pkthdr_pkg.sv
// Shared types and codes for the packet header parser.
// Used by the parser core, the output stage and the port checker.
package pkthdr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TagW  = 6;
  localparam int unsigned LenW  = 32;

  typedef enum logic [1:0] {
    KIND_TAG     = 2'd0,
    KIND_LENGTH  = 2'd1,
    KIND_BODY    = 2'd2,
    KIND_DISCARD = 2'd3
  } byte_kind_e;

  typedef enum logic [1:0] {
    PART_WHOLE  = 2'd0,
    PART_FIRST  = 2'd1,
    PART_MIDDLE = 2'd2,
    PART_FINAL  = 2'd3
  } part_status_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOP_CLEAR = 3'd1,
    ERR_TAG_ZERO  = 3'd2,
    ERR_TAG_UNDEF = 3'd3,
    ERR_TRUNCATED = 3'd4
  } error_code_e;

  typedef struct packed {
    logic [1:0]      byte_kind;
    logic [ByteW-1:0] body_data;
    logic [TagW-1:0] packet_tag;
    logic            new_format;
    logic [LenW-1:0] chunk_length;
    logic            length_ready;
    logic [1:0]      part_status;
    logic            to_stream_end;
    logic            packet_end;
    logic [2:0]      error_code;
  } result_t;

  // Tags 1..14, 17..19 and 60..63 are the defined packet types.
  function automatic logic tag_defined(input logic [TagW-1:0] t);
    logic ok;
    ok = ((t >= 6'd1) && (t <= 6'd14)) || ((t >= 6'd17) && (t <= 6'd19)) || (t >= 6'd60);
    return ok;
  endfunction

endpackage

### rtl/pgp_packet_header_parser.sv
// An accepted octet's result item is registered and appears at the outputs in the cycle after it is accepted.
// Throughput: one octet per cycle while the consumer takes results; the result register frees as it is read.
// The parser state updates in the same cycle an octet is accepted.
// Reset (rst_ni low, asynchronous) returns the parser to expecting a tag octet
// and empties the result register.
module pgp_packet_header_parser import pkthdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] stream_byte_i,
  input  logic             stream_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       byte_kind_o,
  output logic [ByteW-1:0] body_data_o,
  output logic [TagW-1:0]  packet_tag_o,
  output logic             new_format_o,
  output logic [LenW-1:0]  chunk_length_o,
  output logic             length_ready_o,
  output logic [1:0]       part_status_o,
  output logic             to_stream_end_o,
  output logic             packet_end_o,
  output logic [2:0]       error_code_o
);

  logic    accept;
  logic    free;
  result_t res_d;
  result_t res_q;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  pkthdr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .stream_last_i (stream_last_i),
    .result_o      (res_d)
  );

  pkthdr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (res_d),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_q)
  );

  assign byte_kind_o     = res_q.byte_kind;
  assign body_data_o     = res_q.body_data;
  assign packet_tag_o    = res_q.packet_tag;
  assign new_format_o    = res_q.new_format;
  assign chunk_length_o  = res_q.chunk_length;
  assign length_ready_o  = res_q.length_ready;
  assign part_status_o   = res_q.part_status;
  assign to_stream_end_o = res_q.to_stream_end;
  assign packet_end_o    = res_q.packet_end;
  assign error_code_o    = res_q.error_code;

endmodule

### rtl/pkthdr_core.sv
// Parser state and the per-octet decode that builds one result item.
// Depends on pkthdr_pkg.
module pkthdr_core import pkthdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] stream_byte_i,
  input  logic             stream_last_i,
  output result_t          result_o
);

  typedef enum logic [2:0] {
    PH_TAG       = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_MORE  = 3'd2,
    PH_LEN_NEW2  = 3'd3,
    PH_BODY      = 3'd4,
    PH_TO_END    = 3'd5,
    PH_ERROR     = 3'd6
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            fmt_q, fmt_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [2:0]      left_q, left_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [1:0]      pmode_q, pmode_d;

  logic            fin;
  logic            fin_partial;
  logic [LenW-1:0] fin_len;
  logic [1:0]      fin_status;
  logic            discarded;
  logic            nf;
  logic [TagW-1:0] t;
  logic [2:0]      code;
  logic [LenW-1:0] acc_shift;
  logic [2:0]      left_dec;
  logic [LenW-1:0] rem_dec;
  logic [ByteW-1:0] b;

  assign b = stream_byte_i;

  always_comb begin
    result_o            = '0;
    result_o.body_data  = b;
    phase_d     = phase_q;
    fmt_d       = fmt_q;
    tag_d       = tag_q;
    acc_d       = acc_q;
    left_d      = left_q;
    rem_d       = rem_q;
    pmode_d     = pmode_q;
    fin         = 1'b0;
    fin_partial = 1'b0;
    fin_len     = '0;
    discarded   = 1'b0;
    nf          = b[6];
    t           = nf ? b[5:0] : {2'b00, b[5:2]};
    code        = ERR_NONE;
    acc_shift   = {acc_q[LenW-ByteW-1:0], b};
    left_dec    = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
    rem_dec     = (rem_q != '0) ? rem_q - LenW'(1) : '0;

    case (phase_q)
      PH_TAG: begin
        if (!b[7]) code = ERR_TOP_CLEAR;
        else if (t == '0) code = ERR_TAG_ZERO;
        else if (!tag_defined(t)) code = ERR_TAG_UNDEF;
        if (code != ERR_NONE) begin
          result_o.byte_kind  = KIND_DISCARD;
          result_o.body_data  = b;
          result_o.error_code = code;
          discarded = 1'b1;
          phase_d   = PH_ERROR;
        end else begin
          tag_d   = t;
          fmt_d   = nf;
          pmode_d = PART_WHOLE;
          acc_d   = '0;
          result_o.byte_kind  = KIND_TAG;
          result_o.packet_tag = t;
          result_o.new_format = nf;
          if (nf) begin
            phase_d = PH_LEN_FIRST;
          end else if (b[1:0] == 2'd3) begin
            // Indeterminate length: the body runs to the stream's last octet.
            result_o.to_stream_end = 1'b1;
            result_o.packet_end    = stream_last_i;
            phase_d = PH_TO_END;
          end else begin
            case (b[1:0])
              2'd0:    left_d = 3'd1;
              2'd1:    left_d = 3'd2;
              default: left_d = 3'd4;
            endcase
            phase_d = PH_LEN_MORE;
          end
        end
      end
      PH_LEN_FIRST: begin
        result_o.byte_kind  = KIND_LENGTH;
        result_o.packet_tag = tag_q;
        result_o.new_format = fmt_q;
        if (b < 8'd192) begin
          fin     = 1'b1;
          fin_len = LenW'(b);
        end else if (b <= 8'd223) begin
          acc_d   = LenW'(b);
          phase_d = PH_LEN_NEW2;
        end else if (b == 8'd255) begin
          acc_d   = '0;
          left_d  = 3'd4;
          phase_d = PH_LEN_MORE;
        end else begin
          fin         = 1'b1;
          fin_partial = 1'b1;
          fin_len     = LenW'(1) << b[4:0];
        end
      end
      PH_LEN_NEW2: begin
        result_o.byte_kind  = KIND_LENGTH;
        result_o.packet_tag = tag_q;
        result_o.new_format = fmt_q;
        fin     = 1'b1;
        fin_len = ({16'd0, acc_q[7:0], b} - LenW'(192 << 8)) + LenW'(192);
      end
      PH_LEN_MORE: begin
        result_o.byte_kind  = KIND_LENGTH;
        result_o.packet_tag = tag_q;
        result_o.new_format = fmt_q;
        acc_d  = acc_shift;
        left_d = left_dec;
        if (left_dec == 3'd0) begin
          fin     = 1'b1;
          fin_len = acc_shift;
        end
      end
      PH_BODY: begin
        result_o.byte_kind   = KIND_BODY;
        result_o.packet_tag  = tag_q;
        result_o.new_format  = fmt_q;
        result_o.part_status = pmode_q;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          if (pmode_q == PART_FIRST || pmode_q == PART_MIDDLE) begin
            phase_d = PH_LEN_FIRST;
          end else begin
            result_o.packet_end = 1'b1;
            pmode_d = PART_WHOLE;
            phase_d = PH_TAG;
          end
        end
      end
      PH_TO_END: begin
        result_o.byte_kind     = KIND_BODY;
        result_o.packet_tag    = tag_q;
        result_o.new_format    = fmt_q;
        result_o.to_stream_end = 1'b1;
        result_o.packet_end    = stream_last_i;
      end
      default: begin
        // Error latched: everything up to the stream's end is dropped.
        result_o.byte_kind = KIND_DISCARD;
        discarded = 1'b1;
      end
    endcase

    // A completed length header either ends an empty packet or opens a body.
    if (pmode_q != PART_WHOLE) fin_status = fin_partial ? PART_MIDDLE : PART_FINAL;
    else fin_status = fin_partial ? PART_FIRST : PART_WHOLE;
    if (fin) begin
      result_o.chunk_length = fin_len;
      result_o.length_ready = 1'b1;
      result_o.part_status  = fin_status;
      acc_d  = fin_len;
      left_d = 3'd0;
      if (!fin_partial && fin_len == '0) begin
        result_o.packet_end = 1'b1;
        pmode_d = PART_WHOLE;
        phase_d = PH_TAG;
      end else begin
        pmode_d = fin_status;
        rem_d   = fin_len;
        phase_d = PH_BODY;
      end
    end

    if (stream_last_i) begin
      if (!discarded && !result_o.packet_end) result_o.error_code = ERR_TRUNCATED;
      phase_d = PH_TAG;
      fmt_d   = 1'b0;
      tag_d   = '0;
      acc_d   = '0;
      left_d  = 3'd0;
      rem_d   = '0;
      pmode_d = PART_WHOLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      fmt_q   <= 1'b0;
      tag_q   <= '0;
      acc_q   <= '0;
      left_q  <= 3'd0;
      rem_q   <= '0;
      pmode_q <= PART_WHOLE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      fmt_q   <= fmt_d;
      tag_q   <= tag_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      rem_q   <= rem_d;
      pmode_q <= pmode_d;
    end
  end

endmodule

### rtl/pkthdr_out_stage.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on pkthdr_pkg for the result item type.
module pkthdr_out_stage import pkthdr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  // The register frees up in the same cycle its item is taken.
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

### rtl/pkthdr_checker.sv
// Port-level checks for the packet header parser, bound to the top level.
// Depends on pkthdr_pkg for the kind and error codes.
module pkthdr_port_checks import pkthdr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       byte_kind_o,
  input logic [ByteW-1:0] body_data_o,
  input logic [LenW-1:0]  chunk_length_o,
  input logic             length_ready_o,
  input logic [1:0]       part_status_o,
  input logic             packet_end_o,
  input logic [2:0]       error_code_o
);

  // A stalled item stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(body_data_o)
      && $stable(byte_kind_o) && $stable(chunk_length_o))
    else $error("result item changed while stalled");

  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_ready_o |-> byte_kind_o == KIND_LENGTH)
    else $error("length completed on a non-length octet");

  a_tag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == KIND_TAG
      |-> part_status_o == PART_WHOLE && chunk_length_o == '0 && !length_ready_o)
    else $error("tag octet carries length information");

  a_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == KIND_DISCARD
      |-> !packet_end_o && !length_ready_o && error_code_o != ERR_TRUNCATED)
    else $error("discarded octet reports packet progress");

  a_hdr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_TOP_CLEAR || error_code_o == ERR_TAG_ZERO
      || error_code_o == ERR_TAG_UNDEF) |-> byte_kind_o == KIND_DISCARD)
    else $error("header error on a kept octet");

endmodule

bind pgp_packet_header_parser pkthdr_port_checks u_pkthdr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_kind_o    (byte_kind_o),
  .body_data_o    (body_data_o),
  .chunk_length_o (chunk_length_o),
  .length_ready_o (length_ready_o),
  .part_status_o  (part_status_o),
  .packet_end_o   (packet_end_o),
  .error_code_o   (error_code_o)
);

### sim/pkthdr_checker.sv
// Scoreboard for the packet header parser: watches both handshake channels,
// predicts the result item of every accepted octet and compares it with the DUT.
// Depends on pkthdr_pkg for the result layout and the kind/part/error codes.
`timescale 1ns / 1ps

module pkthdr_checker import pkthdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ByteW-1:0] stream_byte_i,
  input  logic             stream_last_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       byte_kind_i,
  input  logic [ByteW-1:0] body_data_i,
  input  logic [TagW-1:0]  packet_tag_i,
  input  logic             new_format_i,
  input  logic [LenW-1:0]  chunk_length_i,
  input  logic             length_ready_i,
  input  logic [1:0]       part_status_i,
  input  logic             to_stream_end_i,
  input  logic             packet_end_i,
  input  logic [2:0]       error_code_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o
);

  typedef enum logic [2:0] {
    ST_TAG,
    ST_LEN_FIRST,
    ST_LEN_OCTETS,
    ST_LEN_SECOND,
    ST_BODY,
    ST_TO_END,
    ST_DISCARD
  } parse_state_e;

  parse_state_e    state_q;
  logic            fmt_q;
  logic [TagW-1:0] tag_q;
  logic [LenW-1:0] len_acc_q;
  logic [2:0]      len_left_q;
  logic [LenW-1:0] body_left_q;
  part_status_e    chunk_mode_q;
  logic            discard_q;

  result_t     expected_q[$];
  int unsigned fails = 0;
  int unsigned checked = 0;

  function automatic void clear_parser();
    state_q      = ST_TAG;
    fmt_q        = 1'b0;
    tag_q        = '0;
    len_acc_q    = '0;
    len_left_q   = '0;
    body_left_q  = '0;
    chunk_mode_q = PART_WHOLE;
    discard_q    = 1'b0;
  endfunction

  // A length header is complete: report it and decide what follows.
  function automatic void close_length(input logic [LenW-1:0] len, input logic partial,
                                       inout result_t r);
    part_status_e st;
    if (chunk_mode_q != PART_WHOLE) st = partial ? PART_MIDDLE : PART_FINAL;
    else st = partial ? PART_FIRST : PART_WHOLE;
    r.chunk_length = len;
    r.length_ready = 1'b1;
    r.part_status  = st;
    len_acc_q  = len;
    len_left_q = '0;
    if (!partial && len == '0) begin
      r.packet_end = 1'b1;
      chunk_mode_q = PART_WHOLE;
      state_q      = ST_TAG;
    end else begin
      chunk_mode_q = st;
      body_left_q  = len;
      state_q      = ST_BODY;
    end
  endfunction

  function automatic result_t predict_octet(input logic [ByteW-1:0] b, input logic last);
    result_t         r;
    logic [TagW-1:0] t;
    error_code_e     code;
    logic [LenW-1:0] pair;
    r = '0;
    r.body_data = b;
    if (discard_q || state_q == ST_DISCARD) begin
      r.byte_kind = KIND_DISCARD;
      if (last) clear_parser();
      return r;
    end
    case (state_q)
      ST_TAG: begin
        code = ERR_NONE;
        t    = '0;
        if (!b[7]) begin
          code = ERR_TOP_CLEAR;
        end else begin
          t = b[6] ? b[5:0] : {2'b00, b[5:2]};
          if (t == '0) code = ERR_TAG_ZERO;
          else if (!(t inside {[6'd1:6'd14], [6'd17:6'd19], [6'd60:6'd63]}))
            code = ERR_TAG_UNDEF;
        end
        if (code != ERR_NONE) begin
          r.byte_kind  = KIND_DISCARD;
          r.error_code = code;
          if (last) begin
            clear_parser();
          end else begin
            discard_q = 1'b1;
            state_q   = ST_DISCARD;
          end
          return r;
        end
        tag_q        = t;
        fmt_q        = b[6];
        chunk_mode_q = PART_WHOLE;
        len_acc_q    = '0;
        r.byte_kind  = KIND_TAG;
        r.packet_tag = t;
        r.new_format = b[6];
        if (b[6]) begin
          state_q = ST_LEN_FIRST;
        end else if (b[1:0] == 2'd3) begin
          // Indeterminate length: the body runs to the end of the stream.
          r.to_stream_end = 1'b1;
          r.packet_end    = last;
          state_q         = ST_TO_END;
        end else begin
          len_left_q = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
          state_q    = ST_LEN_OCTETS;
        end
      end
      ST_LEN_FIRST: begin
        r.byte_kind  = KIND_LENGTH;
        r.packet_tag = tag_q;
        r.new_format = fmt_q;
        if (b < 8'd192) begin
          close_length({24'd0, b}, 1'b0, r);
        end else if (b <= 8'd223) begin
          len_acc_q = {24'd0, b};
          state_q   = ST_LEN_SECOND;
        end else if (b == 8'd255) begin
          len_acc_q  = '0;
          len_left_q = 3'd4;
          state_q    = ST_LEN_OCTETS;
        end else begin
          close_length(32'd1 << b[4:0], 1'b1, r);
        end
      end
      ST_LEN_SECOND: begin
        r.byte_kind  = KIND_LENGTH;
        r.packet_tag = tag_q;
        r.new_format = fmt_q;
        pair = {16'd0, len_acc_q[7:0], b};
        close_length(pair - (32'd192 << 8) + 32'd192, 1'b0, r);
      end
      ST_LEN_OCTETS: begin
        r.byte_kind  = KIND_LENGTH;
        r.packet_tag = tag_q;
        r.new_format = fmt_q;
        len_acc_q = {len_acc_q[23:0], b};
        if (len_left_q != '0) len_left_q = len_left_q - 3'd1;
        if (len_left_q == '0) close_length(len_acc_q, 1'b0, r);
      end
      ST_BODY: begin
        r.byte_kind   = KIND_BODY;
        r.packet_tag  = tag_q;
        r.new_format  = fmt_q;
        r.part_status = chunk_mode_q;
        if (body_left_q != '0) body_left_q = body_left_q - 32'd1;
        if (body_left_q == '0) begin
          // A first or middle chunk is followed by another length header.
          if (chunk_mode_q == PART_FIRST || chunk_mode_q == PART_MIDDLE) begin
            state_q = ST_LEN_FIRST;
          end else begin
            r.packet_end = 1'b1;
            chunk_mode_q = PART_WHOLE;
            state_q      = ST_TAG;
          end
        end
      end
      default: begin
        r.byte_kind     = KIND_BODY;
        r.packet_tag    = tag_q;
        r.new_format    = fmt_q;
        r.to_stream_end = 1'b1;
        r.packet_end    = last;
      end
    endcase
    if (last) begin
      if (!r.packet_end) r.error_code = ERR_TRUNCATED;
      clear_parser();
    end
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return {$sformatf("kind %0d data %02h tag %0d nf %0d len %0d ",
                      r.byte_kind, r.body_data, r.packet_tag, r.new_format,
                      r.chunk_length),
            $sformatf("rdy %0d part %0d eos %0d end %0d err %0d",
                      r.length_ready, r.part_status, r.to_stream_end, r.packet_end,
                      r.error_code)};
  endfunction

  function automatic string field_diffs(input result_t e, input result_t g);
    string s = "";
    if (e.byte_kind !== g.byte_kind)         s = {s, " byte_kind"};
    if (e.body_data !== g.body_data)         s = {s, " body_data"};
    if (e.packet_tag !== g.packet_tag)       s = {s, " packet_tag"};
    if (e.new_format !== g.new_format)       s = {s, " new_format"};
    if (e.chunk_length !== g.chunk_length)   s = {s, " chunk_length"};
    if (e.length_ready !== g.length_ready)   s = {s, " length_ready"};
    if (e.part_status !== g.part_status)     s = {s, " part_status"};
    if (e.to_stream_end !== g.to_stream_end) s = {s, " to_stream_end"};
    if (e.packet_end !== g.packet_end)       s = {s, " packet_end"};
    if (e.error_code !== g.error_code)       s = {s, " error_code"};
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    string   diffs;
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(), predict_octet(stream_byte_i, stream_last_i));
      if (out_valid_i && out_ready_i) begin
        got = {byte_kind_i, body_data_i, packet_tag_i, new_format_i, chunk_length_i,
               length_ready_i, part_status_i, to_stream_end_i, packet_end_i, error_code_i};
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("%0t: result item with none expected: %s", $time,
                                   show_result(got));
          fails++;
        end else begin
          want  = expected_q.pop_front();
          diffs = field_diffs(want, got);
          if (diffs != "") begin
            if (fails < 10) begin
              $display("%0t: result %0d differs in%s", $time, checked, diffs);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
            fails++;
          end
          checked++;
        end
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

### sim/tb_top.sv
// Top of the packet header parser testbench: clock, reset, octet stream stimulus,
// receiver back-pressure, watchdog and verdict. Needs pkthdr_pkg, the parser RTL
// and pkthdr_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_top;
  import pkthdr_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int IdleLimit    = 5000;
  localparam int HoldCycles   = 400;
  localparam int HoldAfter    = 600;
  localparam int DrainAt      = 1200;
  localparam int RandomOctets = 1875;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } octet_item_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [ByteW-1:0] stream_byte;
  logic             stream_last;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       byte_kind;
  logic [ByteW-1:0] body_data;
  logic [TagW-1:0]  packet_tag;
  logic             new_format;
  logic [LenW-1:0]  chunk_length;
  logic             length_ready;
  logic [1:0]       part_status;
  logic             to_stream_end;
  logic             packet_end;
  logic [2:0]       error_code;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent_cnt = 0;
  int unsigned stream_cnt = 0;

  octet_item_t stream_q[$];

  pgp_packet_header_parser u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .stream_byte_i  (stream_byte),
    .stream_last_i  (stream_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .byte_kind_o    (byte_kind),
    .body_data_o    (body_data),
    .packet_tag_o   (packet_tag),
    .new_format_o   (new_format),
    .chunk_length_o (chunk_length),
    .length_ready_o (length_ready),
    .part_status_o  (part_status),
    .to_stream_end_o(to_stream_end),
    .packet_end_o   (packet_end),
    .error_code_o   (error_code)
  );

  pkthdr_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .stream_byte_i  (stream_byte),
    .stream_last_i  (stream_last),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .byte_kind_i    (byte_kind),
    .body_data_i    (body_data),
    .packet_tag_i   (packet_tag),
    .new_format_i   (new_format),
    .chunk_length_i (chunk_length),
    .length_ready_i (length_ready),
    .part_status_i  (part_status),
    .to_stream_end_i(to_stream_end),
    .packet_end_i   (packet_end),
    .error_code_i   (error_code),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  task automatic push_octet(input logic [7:0] b);
    octet_item_t it;
    it.octet = b;
    it.last  = 1'b0;
    stream_q.insert(stream_q.size(), it);
  endtask

  task automatic end_stream();
    stream_q[stream_q.size() - 1].last = 1'b1;
    stream_cnt++;
  endtask

  task automatic add_body(input int unsigned n);
    repeat (n) push_octet(8'($urandom_range(0, 255)));
  endtask

  // Defined tags only: 1..14, 17..19 and 60..63.
  function automatic logic [5:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 20);
    if (r < 14) return 6'(r + 1);
    else if (r < 17) return 6'(r + 3);
    return 6'(r + 43);
  endfunction

  // One well-formed packet; an indeterminate old-format packet only when the
  // stream is to end right after it.
  task automatic add_packet(input bit may_run_open);
    logic [5:0]  tag;
    logic [31:0] len;
    logic [31:0] off;
    int unsigned lt;
    int unsigned e;
    int unsigned enc;
    if ($urandom_range(0, 1) == 1) begin
      tag = pick_tag();
      push_octet({2'b11, tag});
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          e = $urandom_range(0, 4);
          push_octet(8'hE0 | 8'(e));
          add_body(1 << e);
        end
      end
      enc = $urandom_range(0, 9);
      if (enc < 6) begin
        len = $urandom_range(0, 14);
        push_octet(len[7:0]);
      end else if (enc < 8) begin
        off = (enc == 7) ? $urandom_range(250, 300) : $urandom_range(0, 40);
        len = off + 32'd192;
        push_octet(8'd192 + off[15:8]);
        push_octet(off[7:0]);
      end else begin
        len = $urandom_range(0, 14);
        push_octet(8'd255);
        push_octet(len[31:24]);
        push_octet(len[23:16]);
        push_octet(len[15:8]);
        push_octet(len[7:0]);
      end
      add_body(len);
    end else begin
      tag = 6'($urandom_range(1, 14));
      if (may_run_open && $urandom_range(0, 5) == 0) begin
        push_octet({2'b10, tag[3:0], 2'b11});
        add_body($urandom_range(0, 10));
      end else begin
        lt  = $urandom_range(0, 2);
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 16);
        if (lt == 1 && $urandom_range(0, 9) == 0) len = $urandom_range(256, 300);
        push_octet({2'b10, tag[3:0], 2'(lt)});
        if (lt == 2) begin
          push_octet(len[31:24]);
          push_octet(len[23:16]);
        end
        if (lt != 0) push_octet(len[15:8]);
        push_octet(len[7:0]);
        add_body(len);
      end
    end
  endtask

  task automatic add_stream();
    int unsigned first;
    int unsigned n;
    int unsigned sel;
    int unsigned cut;
    first = stream_q.size();
    sel   = $urandom_range(0, 99);
    if (sel < 80) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) add_packet(i == n - 1);
    end else if (sel < 92) begin
      // Well-formed packets cut short at a random octet.
      n = $urandom_range(1, 3);
      repeat (n) add_packet(1'b0);
      cut = $urandom_range(first, stream_q.size() - 1);
      while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
    end else begin
      add_body($urandom_range(1, 8));
    end
    end_stream();
  endtask

  task automatic add_directed();
    // Top bit clear, then a discarded octet closing the stream.
    push_octet(8'h00); push_octet(8'hFF); end_stream();
    // New-format tag zero, then an undefined tag.
    push_octet(8'hC0); end_stream();
    push_octet(8'hCF); end_stream();
    // Old format: zero-length packet, then an indeterminate one to stream end.
    push_octet(8'h88); push_octet(8'h00);
    push_octet(8'h8B); push_octet(8'h55); push_octet(8'hAA); end_stream();
    // Tag 63: one-octet partial chunk, then a five-octet final length.
    push_octet(8'hFF); push_octet(8'hE0); push_octet(8'h12);
    push_octet(8'hFF); push_octet(8'h00); push_octet(8'h00); push_octet(8'h00);
    push_octet(8'h01); push_octet(8'hFE); end_stream();
    // Stream ends on a length octet.
    push_octet(8'h84); push_octet(8'h05); end_stream();
    // First length octet 223 is a two-octet length; the body is cut short.
    push_octet(8'hC2); push_octet(8'hDF); push_octet(8'h00);
    push_octet(8'h3C); push_octet(8'hC3); end_stream();
  endtask

  // Receiver: ready pattern changes mode at random intervals, with one long
  // hold-off while the sender keeps offering octets.
  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held;
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 200);
      for (int k = 0; k < span; k++) begin
        if (!held && sent_cnt >= HoldAfter) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (k % 4) != 3;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results still due", IdleLimit,
             pending);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    stream_byte = '0;
    stream_last = 1'b0;
    burst_left  = 0;
    add_directed();
    while (stream_q.size() < 25 + RandomOctets) add_stream();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stream_q[i]) begin
      if (i == DrainAt) begin
        // Let the parser drain completely before going on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 40);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid    <= 1'b1;
      stream_byte <= stream_q[i].octet;
      stream_last <= stream_q[i].last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent_cnt++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d octets in %0d streams (errors, partial chunks, truncation, open bodies);",
             sent_cnt, stream_cnt);
    $display("compared %0d result items, %0d mismatching or unexpected.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
